>>> hdl/ppbl_pkg.sv
package ppbl_pkg;

   localparam int PORTS_DEF    = 4;
   localparam int CAPACITY_DEF = 256;
   localparam int EVICT_DEF    = 25;

   typedef enum logic [2:0] {
      CMD_REGISTER  = 3'd0,
      CMD_LOAD      = 3'd1,
      CMD_LOAD_DONE = 3'd2,
      CMD_UNREG     = 3'd3,
      CMD_ADD       = 3'd4,
      CMD_REMOVE    = 3'd5,
      CMD_QUERY     = 3'd6,
      CMD_SPARE     = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      PST_NONE    = 2'd0,
      PST_LOADING = 2'd1,
      PST_READY   = 2'd2
   } pstate_type;

   typedef enum logic [1:0] {
      STS_OK      = 2'd0,
      STS_STATE   = 2'd1,
      STS_SERVICE = 2'd2,
      STS_FULL    = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      FSM_IDLE,
      FSM_DECIDE,
      FSM_SCAN_RD,
      FSM_SCAN_CHK,
      FSM_SHIFT_RD,
      FSM_SHIFT_WR,
      FSM_APPEND,
      FSM_FIND_RD,
      FSM_FIND_CHK,
      FSM_DONE
   } fsm_type;

endpackage

>>> hdl/per_port_id_block_list_top.sv
// Register and unregister answer without a list scan; load entry, load done and
// query scan the list of the port for the ID, and an add that evicts scans, moves
// each kept ID down, appends and rescans.
// One item at a time: the next request beat is taken after the result beat leaves.
// Synchronous active-high reset empties all lists and unregisters every port.
module per_port_id_block_list_top #(
   parameter int PORTS    = ppbl_pkg::PORTS_DEF,
   parameter int CAPACITY = ppbl_pkg::CAPACITY_DEF,
   parameter int EVICT    = ppbl_pkg::EVICT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // Fields from bit 0: command[2:0], port[4:3], player_id[68:5],
   // service_ok[69], zero padding to 72 bits.
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // Fields from bit 0: status[1:0], is_listed[2], entry_count[11:3],
   // port_state[13:12], all_up_to_date[14], zero padding to 16 bits.
   output logic [15:0] rsp_tdata
);

   localparam int PW = (PORTS > 1) ? $clog2(PORTS) : 1;
   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(PORTS * CAPACITY);
   localparam int DEPTH = PORTS * CAPACITY;

   ppbl_pkg::fsm_type fsm_ff, fsm_in;

   logic [2:0]  cmd_ff, cmd_in;
   logic [1:0]  port_ff, port_in;
   logic [63:0] id_ff, id_in;
   logic        ok_ff, ok_in;
   logic [CW-1:0] idx_ff, idx_in;    // scan or move index
   logic [CW-1:0] end_ff, end_in;
   logic [CW-1:0] src_ff, src_in;
   logic        found_ff, found_in;
   logic [1:0]  sts_ff, sts_in;

   logic [CW-1:0] cnt_ff [PORTS];
   logic [1:0]    pst_ff [PORTS];
   logic [CW-1:0] cnt_wr;
   logic [1:0]    pst_wr;
   logic          cnt_we, pst_we;

   logic          rvalid_ff, rvalid_in;
   logic [15:0]   rdata_ff, rdata_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [63:0]   wr_data, rd_data;

   logic          port_ok;
   logic [PW-1:0] p;
   logic [CW-1:0] cur_cnt;
   logic [1:0]    cur_pst;
   logic          all_ready;
   logic [CW-1:0] ev;

   ppbl_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   function automatic logic [AW-1:0] addr_of(input logic [PW-1:0] pp,
                                             input logic [CW-1:0] ii);
      logic [AW+CW-1:0] a;
      a = (AW+CW)'(pp) * (AW+CW)'(CAPACITY) + (AW+CW)'(ii[IW-1:0]);
      return a[AW-1:0];
   endfunction

   assign p       = PW'(port_ff);
   assign port_ok = ({30'd0, port_ff} < 32'(PORTS));
   assign cur_cnt = port_ok ? cnt_ff[p] : '0;
   assign cur_pst = port_ok ? pst_ff[p] : ppbl_pkg::PST_NONE;
   assign ev      = (EVICT >= CAPACITY) ? CW'(CAPACITY) : CW'(EVICT);

   always_comb begin
      all_ready = 1'b1;
      for (int k = 0; k < PORTS; k++) begin
         if (pst_ff[k] == ppbl_pkg::PST_LOADING) begin
            all_ready = 1'b0;
         end
      end
   end

   assign req_tready = (fsm_ff == ppbl_pkg::FSM_IDLE) && !rvalid_ff;
   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = rdata_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff    <= ppbl_pkg::FSM_IDLE;
         rvalid_ff <= 1'b0;
         for (int k = 0; k < PORTS; k++) begin
            cnt_ff[k] <= '0;
            pst_ff[k] <= ppbl_pkg::PST_NONE;
         end
      end else begin
         fsm_ff    <= fsm_in;
         rvalid_ff <= rvalid_in;
         if (cnt_we && port_ok) begin
            cnt_ff[p] <= cnt_wr;
         end
         if (pst_we && port_ok) begin
            pst_ff[p] <= pst_wr;
         end
      end
      cmd_ff   <= cmd_in;
      port_ff  <= port_in;
      id_ff    <= id_in;
      ok_ff    <= ok_in;
      idx_ff   <= idx_in;
      end_ff   <= end_in;
      src_ff   <= src_in;
      found_ff <= found_in;
      sts_ff   <= sts_in;
      rdata_ff <= rdata_in;
   end

   always_comb begin
      fsm_in    = fsm_ff;
      cmd_in    = cmd_ff;
      port_in   = port_ff;
      id_in     = id_ff;
      ok_in     = ok_ff;
      idx_in    = idx_ff;
      end_in    = end_ff;
      src_in    = src_ff;
      found_in  = found_ff;
      sts_in    = sts_ff;
      rvalid_in = rvalid_ff && !rsp_tready;
      rdata_in  = rdata_ff;
      cnt_we    = 1'b0;
      cnt_wr    = cur_cnt;
      pst_we    = 1'b0;
      pst_wr    = cur_pst;
      wr_en     = 1'b0;
      wr_addr   = addr_of(p, idx_ff);
      wr_data   = id_ff;
      rd_addr   = addr_of(p, idx_ff);

      unique case (fsm_ff)
         ppbl_pkg::FSM_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd_in  = req_tdata[2:0];
               port_in = req_tdata[4:3];
               id_in   = req_tdata[68:5];
               ok_in   = req_tdata[69];
               sts_in  = ppbl_pkg::STS_OK;
               fsm_in  = ppbl_pkg::FSM_DECIDE;
            end
         end
         ppbl_pkg::FSM_DECIDE: begin
            idx_in   = '0;
            found_in = 1'b0;
            fsm_in   = ppbl_pkg::FSM_FIND_RD;
            if (!port_ok) begin
               sts_in = ppbl_pkg::STS_STATE;
               fsm_in = ppbl_pkg::FSM_DONE;
            end else begin
               unique case (ppbl_pkg::cmd_type'(cmd_ff))
                  ppbl_pkg::CMD_REGISTER: begin
                     cnt_we = 1'b1;
                     cnt_wr = '0;
                     pst_we = 1'b1;
                     pst_wr = ok_ff ? ppbl_pkg::PST_LOADING : ppbl_pkg::PST_READY;
                  end
                  ppbl_pkg::CMD_LOAD: begin
                     if (cur_pst != ppbl_pkg::PST_LOADING) begin
                        sts_in = ppbl_pkg::STS_STATE;
                     end else if (cur_cnt >= CW'(CAPACITY)) begin
                        sts_in = ppbl_pkg::STS_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = addr_of(p, cur_cnt);
                        cnt_we  = 1'b1;
                        cnt_wr  = cur_cnt + 1'b1;
                     end
                  end
                  ppbl_pkg::CMD_LOAD_DONE: begin
                     if (cur_pst != ppbl_pkg::PST_LOADING) begin
                        sts_in = ppbl_pkg::STS_STATE;
                     end else begin
                        pst_we = 1'b1;
                        pst_wr = ppbl_pkg::PST_READY;
                     end
                  end
                  ppbl_pkg::CMD_UNREG: begin
                     cnt_we = 1'b1;
                     cnt_wr = '0;
                     pst_we = 1'b1;
                     pst_wr = ppbl_pkg::PST_NONE;
                  end
                  ppbl_pkg::CMD_ADD, ppbl_pkg::CMD_REMOVE: begin
                     if (cur_pst != ppbl_pkg::PST_READY) begin
                        sts_in = ppbl_pkg::STS_STATE;
                     end else if (!ok_ff) begin
                        sts_in = ppbl_pkg::STS_SERVICE;
                     end else begin
                        fsm_in = ppbl_pkg::FSM_SCAN_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         // Look for the ID before changing anything.
         ppbl_pkg::FSM_SCAN_RD: begin
            if (idx_ff >= cur_cnt) begin
               // Not present.
               if (cmd_ff == ppbl_pkg::CMD_REMOVE) begin
                  idx_in = '0;
                  fsm_in = ppbl_pkg::FSM_FIND_RD;
               end else if (cur_cnt >= CW'(CAPACITY)) begin
                  if (ev >= cur_cnt) begin
                     end_in = '0;
                     fsm_in = ppbl_pkg::FSM_APPEND;
                  end else begin
                     idx_in = '0;
                     src_in = ev;
                     end_in = cur_cnt - ev;
                     fsm_in = ppbl_pkg::FSM_SHIFT_RD;
                  end
               end else begin
                  end_in = cur_cnt;
                  fsm_in = ppbl_pkg::FSM_APPEND;
               end
            end else begin
               fsm_in = ppbl_pkg::FSM_SCAN_CHK;
            end
         end
         ppbl_pkg::FSM_SCAN_CHK: begin
            if (rd_data == id_ff) begin
               if (cmd_ff == ppbl_pkg::CMD_REMOVE) begin
                  src_in = idx_ff + 1'b1;
                  end_in = cur_cnt - 1'b1;
                  fsm_in = ppbl_pkg::FSM_SHIFT_RD;
               end else begin
                  idx_in = '0;
                  fsm_in = ppbl_pkg::FSM_FIND_RD;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
               fsm_in = ppbl_pkg::FSM_SCAN_RD;
            end
         end
         // Move entries down: entry src goes to idx until idx reaches end.
         ppbl_pkg::FSM_SHIFT_RD: begin
            if (idx_ff >= end_ff) begin
               if (cmd_ff == ppbl_pkg::CMD_REMOVE) begin
                  cnt_we = 1'b1;
                  cnt_wr = end_ff;
                  idx_in = '0;
                  fsm_in = ppbl_pkg::FSM_FIND_RD;
               end else begin
                  fsm_in = ppbl_pkg::FSM_APPEND;
               end
            end else begin
               rd_addr = addr_of(p, src_ff);
               fsm_in  = ppbl_pkg::FSM_SHIFT_WR;
            end
         end
         ppbl_pkg::FSM_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_data = rd_data;
            idx_in  = idx_ff + 1'b1;
            src_in  = src_ff + 1'b1;
            fsm_in  = ppbl_pkg::FSM_SHIFT_RD;
         end
         ppbl_pkg::FSM_APPEND: begin
            wr_en   = 1'b1;
            wr_addr = addr_of(p, end_ff);
            cnt_we  = 1'b1;
            cnt_wr  = end_ff + 1'b1;
            idx_in  = '0;
            fsm_in  = ppbl_pkg::FSM_FIND_RD;
         end
         // Final presence check for the response.
         ppbl_pkg::FSM_FIND_RD: begin
            if (!port_ok || idx_ff >= cur_cnt || found_ff) begin
               fsm_in = ppbl_pkg::FSM_DONE;
            end else begin
               fsm_in = ppbl_pkg::FSM_FIND_CHK;
            end
         end
         ppbl_pkg::FSM_FIND_CHK: begin
            if (rd_data == id_ff) begin
               found_in = 1'b1;
            end
            idx_in = idx_ff + 1'b1;
            fsm_in = ppbl_pkg::FSM_FIND_RD;
         end
         ppbl_pkg::FSM_DONE: begin
            rvalid_in = 1'b1;
            rdata_in  = {1'b0, all_ready, cur_pst, 9'(cur_cnt), found_ff, sts_ff};
            fsm_in    = ppbl_pkg::FSM_IDLE;
         end
         default: begin
            fsm_in = ppbl_pkg::FSM_IDLE;
         end
      endcase
   end

endmodule

>>> hdl/ppbl_ram.sv
module ppbl_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
